// File: src/rcdm_pkg.sv
// rcdm_pkg: shared types and constants for the RC differential-drive mixer.
// Holds the controller state type, the command/status structs and pulse thresholds.
// No dependencies.
`default_nettype none

package rcdm_pkg;

	localparam int unsigned MODE_ARCADE_MAX  = 1600;
	localparam int unsigned THR_FWD_LO       = 1425;
	localparam int unsigned PULSE_BAND_LO    = 1475;
	localparam int unsigned PULSE_BAND_HI    = 1525;
	localparam int unsigned PULSE_CENTRE     = 1500;
	localparam int unsigned LIMIT_ZERO       = 1000;
	localparam int unsigned HALF_SPAN        = 500;
	localparam int unsigned ARCADE_DEN       = 500000;
	localparam int unsigned TANK_DEADBAND    = 20;
	localparam int unsigned DEN_W            = 19;
	localparam int unsigned OUT_W            = 24;
	// odd factor and power-of-two shift of each divisor
	localparam int unsigned ARCADE_DEN_ODD   = 15625;
	localparam int unsigned ARCADE_DEN_SHIFT = 5;
	localparam int unsigned HALF_SPAN_ODD    = 125;
	localparam int unsigned HALF_SPAN_SHIFT  = 2;

	typedef enum logic [1:0] {
		DIR_FWD  = 2'd0,
		DIR_REV  = 2'd1,
		DIR_NONE = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_SAVE,
		ST_COMMIT
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic op_sel;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic save0;
		logic save1;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: src/rcdm_dp.sv
// rcdm_dp: mixer datapath - input capture, two-step multiplier, reciprocal divide by
// constant, mixing decision, last-command state and result register. Depends on rcdm_pkg.
`default_nettype none

module rcdm_dp
	import rcdm_pkg::*;
#(
	parameter int PULSE_BITS = 12,
	parameter int SPEED_MAX  = 255,
	parameter int IN_W       = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dp_cmd_t         cmd,
	output dp_sts_t              sts,
	input  wire logic [IN_W-1:0] in_data,
	output logic [OUT_W-1:0]     out_data
);

	localparam int SPD_W = $clog2(SPEED_MAX + 1);
	localparam int A_W   = (PULSE_BITS > SPD_W) ? PULSE_BITS : SPD_W;
	localparam int B_W   = PULSE_BITS + 1;
	localparam int M1_W  = A_W + 1 + B_W;
	localparam int M2_W  = M1_W + SPD_W + 1;
	localparam int REM_W = SPD_W + DEN_W;
	localparam int NUM_W = REM_W - ARCADE_DEN_SHIFT;
	localparam int RCP_W = NUM_W + 1;
	localparam int PRD_W = NUM_W + RCP_W;
	localparam int SH_ARC  = NUM_W + $clog2(ARCADE_DEN_ODD);
	localparam int SH_TANK = SPD_W + $clog2(HALF_SPAN) - HALF_SPAN_SHIFT +
		$clog2(HALF_SPAN_ODD);
	localparam logic [M2_W-1:0] LIM_ARC  = M2_W'(64'(SPEED_MAX + 1) * 64'(ARCADE_DEN));
	localparam logic [M2_W-1:0] LIM_TANK = M2_W'(64'(SPEED_MAX + 1) * 64'(HALF_SPAN));
	localparam logic [SPD_W-1:0] SPD_FULL = SPD_W'(SPEED_MAX);
	localparam logic [RCP_W-1:0] RCP_ARC = RCP_W'(((64'd1 << SH_ARC) +
		64'(ARCADE_DEN_ODD) - 64'd1) / 64'(ARCADE_DEN_ODD));
	localparam logic [RCP_W-1:0] RCP_TANK = RCP_W'(((64'd1 << SH_TANK) +
		64'(HALF_SPAN_ODD) - 64'd1) / 64'(HALF_SPAN_ODD));

	function automatic logic [PULSE_BITS-1:0] centre_dist(input logic [PULSE_BITS-1:0] v);
		if (v >= PULSE_BITS'(PULSE_CENTRE))
			return v - PULSE_BITS'(PULSE_CENTRE);
		return PULSE_BITS'(PULSE_CENTRE) - v;
	endfunction

	logic [PULSE_BITS-1:0]   thr_q, steer_q, rv_q, lim_q;
	logic                    arcade_q;
	logic signed [M1_W-1:0]  m1_q;
	logic signed [M2_W-1:0]  m2_q;
	logic [NUM_W-1:0]        num_q;
	logic [PRD_W-1:0]        prod_q;
	logic [SPD_W-1:0]        res0_q, res1_q;
	logic                    sat_q;
	dir_t                    last_a_dir_q, last_b_dir_q;
	logic [SPD_W-1:0]        last_a_spd_q, last_b_spd_q;
	logic [OUT_W-1:0]        out_q;

	logic                    fwd, rev, left, right;
	logic [PULSE_BITS-1:0]   req, turn, rtr;
	logic signed [B_W-1:0]   lim_ofs, turn_room;
	logic [A_W-1:0]          opa;
	logic signed [B_W-1:0]   opb;
	logic [SPD_W-1:0]        opc;
	logic                    arc_den;
	logic [SPD_W-1:0]        quo;
	dir_t                    a_dir, b_dir;
	logic [SPD_W-1:0]        a_spd, b_spd;
	logic                    go;

	assign fwd       = thr_q < PULSE_BITS'(THR_FWD_LO);
	assign rev       = thr_q > PULSE_BITS'(PULSE_BAND_HI);
	assign left      = steer_q < PULSE_BITS'(PULSE_BAND_LO);
	assign right     = steer_q > PULSE_BITS'(PULSE_BAND_HI);
	assign req       = centre_dist(thr_q);
	assign turn      = centre_dist(steer_q);
	assign rtr       = centre_dist(rv_q);
	assign lim_ofs   = $signed({1'b0, lim_q}) - $signed(B_W'(LIMIT_ZERO));
	assign turn_room = $signed(B_W'(HALF_SPAN)) - $signed({1'b0, turn});

	always_comb begin
		opa     = A_W'(req);
		opb     = lim_ofs;
		opc     = SPD_FULL;
		arc_den = 1'b1;
		if (arcade_q) begin
			if (cmd.op_sel && !(fwd || rev)) begin
				opa = A_W'(turn);
			end else if (cmd.op_sel) begin
				opa     = A_W'(res0_q);
				opb     = turn_room;
				opc     = SPD_W'(1);
				arc_den = 1'b0;
			end
		end else begin
			opa     = A_W'(cmd.op_sel ? rtr : req);
			opb     = B_W'(1);
			arc_den = 1'b0;
		end
	end

	assign quo = sat_q ? SPD_FULL :
		(arc_den ? prod_q[SH_ARC +: SPD_W] : prod_q[SH_TANK +: SPD_W]);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			thr_q    <= in_data[PULSE_BITS +: PULSE_BITS];
			steer_q  <= in_data[2*PULSE_BITS +: PULSE_BITS];
			rv_q     <= in_data[3*PULSE_BITS +: PULSE_BITS];
			lim_q    <= in_data[4*PULSE_BITS +: PULSE_BITS];
			arcade_q <= in_data[0 +: PULSE_BITS] <= PULSE_BITS'(MODE_ARCADE_MAX);
		end
		if (cmd.mul1)
			m1_q <= $signed({1'b0, opa}) * opb;
		if (cmd.mul2)
			m2_q <= m1_q * $signed({1'b0, opc});
		if (cmd.div_init) begin
			if (m2_q[M2_W-1]) begin
				sat_q <= 1'b0;
				num_q <= '0;
			end else if ($unsigned(m2_q) >= (arc_den ? LIM_ARC : LIM_TANK)) begin
				sat_q <= 1'b1;
				num_q <= '0;
			end else begin
				sat_q <= 1'b0;
				num_q <= arc_den ? NUM_W'(m2_q[REM_W-1:0] >> ARCADE_DEN_SHIFT)
				                 : NUM_W'(m2_q[REM_W-1:0] >> HALF_SPAN_SHIFT);
			end
		end else if (cmd.div_step) begin
			prod_q <= PRD_W'(num_q) * PRD_W'(arc_den ? RCP_ARC : RCP_TANK);
		end
		if (cmd.save0)
			res0_q <= quo;
		if (cmd.save1)
			res1_q <= quo;
		if (cmd.commit && sts.emit)
			out_q <= OUT_W'({go, 8'(b_spd), b_dir, 8'(a_spd), a_dir});
	end

	always_comb begin
		a_dir = DIR_NONE;
		b_dir = DIR_NONE;
		a_spd = '0;
		b_spd = '0;
		go    = 1'b0;
		if (arcade_q) begin
			if (fwd || rev || left || right) begin
				go = 1'b1;
				if (!(fwd || rev)) begin
					a_spd = res1_q;
					b_spd = res1_q;
					a_dir = left ? DIR_FWD : DIR_REV;
					b_dir = left ? DIR_REV : DIR_FWD;
				end else begin
					a_dir = fwd ? DIR_FWD : DIR_REV;
					b_dir = a_dir;
					a_spd = right ? res1_q : res0_q;
					b_spd = (left && !right) ? res1_q : res0_q;
				end
			end
		end else begin
			if (32'(res0_q) > TANK_DEADBAND) begin
				go    = 1'b1;
				b_spd = res0_q;
				if (thr_q < PULSE_BITS'(PULSE_BAND_LO))
					b_dir = DIR_FWD;
				else if (thr_q > PULSE_BITS'(PULSE_BAND_HI))
					b_dir = DIR_REV;
			end
			if (32'(res1_q) > TANK_DEADBAND) begin
				go    = 1'b1;
				a_spd = res1_q;
				if (rv_q < PULSE_BITS'(PULSE_BAND_LO))
					a_dir = DIR_FWD;
				else if (rv_q > PULSE_BITS'(PULSE_BAND_HI))
					a_dir = DIR_REV;
			end
		end
	end

	assign sts.emit = (a_dir != last_a_dir_q) || (a_spd != last_a_spd_q) ||
		(b_dir != last_b_dir_q) || (b_spd != last_b_spd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_dir_q <= DIR_NONE;
			last_b_dir_q <= DIR_NONE;
			last_a_spd_q <= '0;
			last_b_spd_q <= '0;
		end else if (cmd.commit && sts.emit) begin
			last_a_dir_q <= a_dir;
			last_b_dir_q <= b_dir;
			last_a_spd_q <= a_spd;
			last_b_spd_q <= b_spd;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// File: src/rcdm_ctrl.sv
// rcdm_ctrl: sequencer for the mixer - input handshake, two multiply/divide passes
// per word, commit and result valid. Depends on rcdm_pkg.
`default_nettype none

module rcdm_ctrl
	import rcdm_pkg::*;
#(
	parameter int DIV_STEPS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic radio_en,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output dp_cmd_t   cmd,
	input  wire dp_sts_t sts
);

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	ctl_state_t       state_q, state_d;
	logic             op_q, op_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             vld_q, vld_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= 1'b0;
			cnt_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			vld_q   <= vld_d;
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.op_sel = op_q;
		state_d    = state_q;
		op_d       = op_q;
		cnt_d      = cnt_q;
		vld_d      = vld_q && !m_tready;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && radio_en) begin
					cmd.capture = 1'b1;
					op_d        = 1'b0;
					state_d     = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = CNT_W'(DIV_STEPS - 1);
				state_d      = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = ST_SAVE;
			end
			ST_SAVE: begin
				cmd.save0 = !op_q;
				cmd.save1 = op_q;
				op_d      = 1'b1;
				state_d   = op_q ? ST_COMMIT : ST_MUL1;
			end
			ST_COMMIT: begin
				if (!(sts.emit && vld_q && !m_tready)) begin
					cmd.commit = 1'b1;
					vld_d      = sts.emit || (vld_q && !m_tready);
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = vld_q;

endmodule

`default_nettype wire

// File: src/rc_differential_drive_mixer_top.sv
// rc_differential_drive_mixer_top: RC differential-drive mixer, arcade and tank style.
// Ties the radio enable register to rcdm_ctrl and rcdm_dp. Depends on rcdm_pkg.
//
// Input channel s_*: one word per receiver tick holding five pulse widths in
// microseconds. A word is taken whenever the block is idle; with the radio
// enable cleared it is taken and dropped at once.
// Output channel m_*: one motor command word, sent only when a direction or a
// speed differs from the last command sent; ticks that change nothing give no word.
// Each word runs two passes: a 2-stage multiplier, a saturation check
// and a divide by a constant done as one reciprocal multiply. A word occupies the
// block until it is committed, so a new word is taken only once the block is idle
// again; its command shows on m_tvalid the cycle after commit.
// The result sits in an output register, so the next word is taken while it
// waits; if a new command is ready while the previous one is still stalled,
// the block holds in commit until the receiver takes the old word.
// Reset clears the last command to no direction and zero speed, sets the radio
// enable and drops any pending word. cfg_we writes the radio enable from cfg_wdata;
// the user must write it only while the block is idle; this is not enforced.
`default_nettype none

module rc_differential_drive_mixer_top
	import rcdm_pkg::*;
#(
	parameter int PULSE_BITS = 12,
	parameter int SPEED_MAX  = 255
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// mode, left vertical, right horizontal, right vertical, speed limit pulses
	input  wire logic [((5*PULSE_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// motor A direction, motor A speed, motor B direction, motor B speed, drive enable
	output logic [OUT_W-1:0]                           m_tdata,
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_wdata
);

	localparam int IN_W  = ((5*PULSE_BITS+7)/8)*8;

	logic    radio_en_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radio_en_q <= 1'b1;
		else if (cfg_we)
			radio_en_q <= cfg_wdata;
	end

	rcdm_ctrl #(
		.DIV_STEPS(1)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.radio_en(radio_en_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	rcdm_dp #(
		.PULSE_BITS(PULSE_BITS),
		.SPEED_MAX (SPEED_MAX),
		.IN_W      (IN_W)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (s_tdata),
		.out_data(m_tdata)
	);

	a_drop_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !radio_en_q) |=> s_tready)
		else $error("word taken with radio disabled left the block busy");

	a_stop_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[20]) |->
		(m_tdata[1:0] == DIR_NONE && m_tdata[9:2] == 8'd0 &&
		 m_tdata[11:10] == DIR_NONE && m_tdata[19:12] == 8'd0))
		else $error("stop command carries a direction or speed");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3 && m_tdata[11:10] != 2'd3))
		else $error("invalid direction code on result");

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && sts.emit) |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/rcdm_tb_pkg.sv
// rcdm_tb_pkg: word layouts and the command scoreboard for the mixer testbench.
// Predicts the motor command for each accepted tick and checks received words.
// Depends on rcdm_pkg for the direction codes.
`timescale 1ns / 1ps

package rcdm_tb_pkg;

	import rcdm_pkg::*;

	localparam longint MIX_SPEED_MAX = 255;
	localparam longint MIX_MODE_MAX  = 1600;
	localparam longint MIX_FWD_BELOW = 1425;
	localparam longint MIX_BAND_LO   = 1475;
	localparam longint MIX_BAND_HI   = 1525;
	localparam longint MIX_CENTRE    = 1500;
	localparam longint MIX_POT_ZERO  = 1000;
	localparam longint MIX_HALF_SPAN = 500;
	localparam longint MIX_POT_DEN   = 500000;
	localparam longint MIX_DEADBAND  = 20;

	// fields from the lowest bit up: mode, left vertical, right horizontal,
	// right vertical, speed limit
	typedef struct packed {
		logic [11:0] speed_limit;
		logic [11:0] right_vertical;
		logic [11:0] right_horizontal;
		logic [11:0] left_vertical;
		logic [11:0] mode;
	} tick_t;

	// fields from the lowest bit up: A direction, A speed, B direction, B speed, enable
	typedef struct packed {
		logic       drive_enable;
		logic [7:0] b_speed;
		dir_t       b_dir;
		logic [7:0] a_speed;
		dir_t       a_dir;
	} motor_cmd_t;

	class mixer_scoreboard;
		bit           radio_on;
		dir_t         last_a_dir;
		dir_t         last_b_dir;
		longint       last_a_speed;
		longint       last_b_speed;
		motor_cmd_t   expected_cmds[$];
		int           errors;

		function new();
			radio_on = 1'b1;
			last_a_dir = DIR_NONE;
			last_b_dir = DIR_NONE;
			last_a_speed = 0;
			last_b_speed = 0;
			errors = 0;
		endfunction

		static function longint clamp_speed(longint v);
			if (v < 0)
				return 0;
			if (v > MIX_SPEED_MAX)
				return MIX_SPEED_MAX;
			return v;
		endfunction

		static function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function bit mix_tick(tick_t t, output motor_cmd_t cmd);
			longint mode, thr, steer, rv, lim;
			longint pot, req, turn, adj, spin, inner, adj_l, adj_r;
			longint a_spd, b_spd;
			dir_t a_dir, b_dir;
			bit go, fwd, rev, left, right;
			mode = t.mode;
			thr = t.left_vertical;
			steer = t.right_horizontal;
			rv = t.right_vertical;
			lim = t.speed_limit;
			a_dir = DIR_NONE;
			b_dir = DIR_NONE;
			a_spd = 0;
			b_spd = 0;
			go = 1'b0;
			if (mode <= MIX_MODE_MAX) begin
				rev = thr > MIX_BAND_HI;
				fwd = thr < MIX_FWD_BELOW;
				left = steer < MIX_BAND_LO;
				right = steer > MIX_BAND_HI;
				if (fwd || rev || left || right) begin
					pot = lim - MIX_POT_ZERO;
					req = magnitude(thr - MIX_CENTRE);
					turn = magnitude(steer - MIX_CENTRE);
					adj = clamp_speed(req * pot * MIX_SPEED_MAX / MIX_POT_DEN);
					go = 1'b1;
					if (!(fwd || rev)) begin
						spin = turn * pot * MIX_SPEED_MAX / MIX_POT_DEN;
						a_spd = spin;
						b_spd = spin;
						if (left) begin
							a_dir = DIR_FWD;
							b_dir = DIR_REV;
						end else begin
							a_dir = DIR_REV;
							b_dir = DIR_FWD;
						end
					end else begin
						inner = adj * (MIX_HALF_SPAN - turn) / MIX_HALF_SPAN;
						a_dir = fwd ? DIR_FWD : DIR_REV;
						b_dir = a_dir;
						if (right) begin
							a_spd = inner;
							b_spd = adj;
						end else if (left) begin
							a_spd = adj;
							b_spd = inner;
						end else begin
							a_spd = adj;
							b_spd = adj;
						end
					end
				end
			end else begin
				adj_l = clamp_speed(magnitude(thr - MIX_CENTRE) * MIX_SPEED_MAX / MIX_HALF_SPAN);
				adj_r = clamp_speed(magnitude(rv - MIX_CENTRE) * MIX_SPEED_MAX / MIX_HALF_SPAN);
				if (adj_l > MIX_DEADBAND) begin
					go = 1'b1;
					if (thr < MIX_BAND_LO)
						b_dir = DIR_FWD;
					else if (thr > MIX_BAND_HI)
						b_dir = DIR_REV;
					b_spd = adj_l;
				end
				if (adj_r > MIX_DEADBAND) begin
					go = 1'b1;
					if (rv < MIX_BAND_LO)
						a_dir = DIR_FWD;
					else if (rv > MIX_BAND_HI)
						a_dir = DIR_REV;
					a_spd = adj_r;
				end
			end
			a_spd = clamp_speed(a_spd);
			b_spd = clamp_speed(b_spd);
			cmd = '0;
			if (a_dir == last_a_dir && a_spd == last_a_speed &&
			    b_dir == last_b_dir && b_spd == last_b_speed)
				return 1'b0;
			last_a_dir = a_dir;
			last_a_speed = a_spd;
			last_b_dir = b_dir;
			last_b_speed = b_spd;
			if (go) begin
				cmd.a_dir = a_dir;
				cmd.a_speed = a_spd[7:0];
				cmd.b_dir = b_dir;
				cmd.b_speed = b_spd[7:0];
				cmd.drive_enable = 1'b1;
			end else begin
				cmd.a_dir = DIR_NONE;
				cmd.a_speed = '0;
				cmd.b_dir = DIR_NONE;
				cmd.b_speed = '0;
				cmd.drive_enable = 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_tick(tick_t t);
			motor_cmd_t cmd;
			if (radio_on && mix_tick(t, cmd))
				expected_cmds.push_back(cmd);
		endfunction

		function void check_command(logic [23:0] word);
			motor_cmd_t got, exp;
			got = motor_cmd_t'(word[20:0]);
			if (expected_cmds.size() == 0) begin
				$error("command word %h with none expected", word);
				errors++;
				return;
			end
			exp = expected_cmds.pop_front();
			if (got.a_dir !== exp.a_dir) begin
				$error("motor_a_direction: expected %0d, got %0d", exp.a_dir, got.a_dir);
				errors++;
			end
			if (got.a_speed !== exp.a_speed) begin
				$error("motor_a_speed: expected %0d, got %0d", exp.a_speed, got.a_speed);
				errors++;
			end
			if (got.b_dir !== exp.b_dir) begin
				$error("motor_b_direction: expected %0d, got %0d", exp.b_dir, got.b_dir);
				errors++;
			end
			if (got.b_speed !== exp.b_speed) begin
				$error("motor_b_speed: expected %0d, got %0d", exp.b_speed, got.b_speed);
				errors++;
			end
			if (got.drive_enable !== exp.drive_enable) begin
				$error("drive_enable: expected %0d, got %0d", exp.drive_enable,
					got.drive_enable);
				errors++;
			end
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

endpackage

// File: tb/rc_differential_drive_mixer_top_tb.sv
// rc_differential_drive_mixer_top_tb: drives receiver ticks into the mixer with random
// gaps and stalls, toggles the radio enable between phases and checks every command word.
// Depends on rcdm_pkg, rcdm_tb_pkg and the mixer RTL.
`timescale 1ns / 1ps

module rc_differential_drive_mixer_top_tb;

	import rcdm_pkg::*;
	import rcdm_tb_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic        cfg_wdata;

	mixer_scoreboard sb;
	bit  tx_calm;
	bit  hold_off_req;
	int  idle_cycles;

	rc_differential_drive_mixer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_tick(tick_t'(s_tdata[59:0]));
			if (m_tvalid && m_tready)
				sb.check_command(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("rc_differential_drive_mixer_top_tb: done, errors");
				$finish;
			end
		end
	end

	// receiver: random stalls, calm stretches and one long hold-off on request
	initial begin
		int stall_left;
		int roll;
		int cycle_count;
		bit rx_calm;
		m_tready = 1'b0;
		stall_left = 0;
		cycle_count = 0;
		rx_calm = 1'b0;
		forever begin
			@(negedge clk);
			cycle_count++;
			if (cycle_count % 256 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_calm) begin
				m_tready <= 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					m_tready <= 1'b1;
				end else if (roll < 95) begin
					stall_left = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else begin
					stall_left = $urandom_range(10, 60);
					m_tready <= 1'b0;
				end
			end
		end
	end

	function automatic int tx_gap();
		int roll;
		if (tx_calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic tick_t make_tick(int mode, int lv, int rh, int rv, int lim);
		tick_t t;
		t.mode = mode[11:0];
		t.left_vertical = lv[11:0];
		t.right_horizontal = rh[11:0];
		t.right_vertical = rv[11:0];
		t.speed_limit = lim[11:0];
		return t;
	endfunction

	function automatic int stick_pulse();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1000, 2000);
		if (roll < 85)
			return $urandom_range(1400, 1600);
		return $urandom_range(0, 4095);
	endfunction

	function automatic tick_t random_tick(tick_t prev);
		int roll;
		int mode;
		int lim;
		if ($urandom_range(0, 99) < 8)
			return prev;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			mode = $urandom_range(900, 1600);
		else if (roll < 85)
			mode = $urandom_range(1601, 2100);
		else
			mode = $urandom_range(0, 4095);
		lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
		                                   : $urandom_range(1000, 2000);
		return make_tick(mode, stick_pulse(), stick_pulse(), stick_pulse(), lim);
	endfunction

	task automatic send_tick(tick_t t);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, t};
		do
			@(posedge clk);
		while (!s_tready);
		gap = tx_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_radio(bit on);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.radio_on = on;
	endtask

	task automatic send_random(int count, int hold_at);
		tick_t prev;
		prev = make_tick(1500, 1500, 1500, 1500, 1500);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			if (i == hold_at)
				hold_off_req = 1'b1;
			prev = random_tick(prev);
			send_tick(prev);
		end
	endtask

	initial begin
		tick_t directed[$];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		tx_calm = 1'b0;
		hold_off_req = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_tick(0, 0, 0, 0, 0));
		directed.push_back(make_tick(4095, 4095, 4095, 4095, 4095));
		directed.push_back(make_tick(1500, 1500, 1500, 1500, 1500));
		directed.push_back(make_tick(1500, 1500, 1500, 1500, 1500));
		directed.push_back(make_tick(1000, 1000, 1500, 1500, 2000));
		directed.push_back(make_tick(1600, 2000, 1500, 1500, 2000));
		directed.push_back(make_tick(1500, 1500, 1000, 1500, 2000));
		directed.push_back(make_tick(1500, 1500, 2000, 1500, 1500));
		directed.push_back(make_tick(1200, 1100, 1800, 1500, 1800));
		directed.push_back(make_tick(1200, 1900, 1300, 1500, 1700));
		directed.push_back(make_tick(1000, 1000, 0, 1500, 2000));
		directed.push_back(make_tick(1000, 1000, 1500, 1500, 4095));
		directed.push_back(make_tick(1000, 1000, 2000, 1500, 500));
		directed.push_back(make_tick(1000, 1500, 1000, 1500, 0));
		directed.push_back(make_tick(1601, 1000, 1500, 2000, 1500));
		directed.push_back(make_tick(1000, 1425, 1474, 1500, 2000));
		directed.push_back(make_tick(1000, 1424, 1475, 1500, 2000));
		directed.push_back(make_tick(1000, 1525, 1526, 1500, 2000));
		directed.push_back(make_tick(1000, 1526, 1525, 1500, 2000));
		directed.push_back(make_tick(2000, 1458, 1500, 1542, 1500));
		directed.push_back(make_tick(2000, 1459, 1500, 1541, 1500));
		directed.push_back(make_tick(3000, 1700, 0, 1500, 0));
		directed.push_back(make_tick(3000, 1500, 4095, 1000, 4095));
		directed.push_back(make_tick(0, 1500, 1500, 4095, 4095));
		foreach (directed[i])
			send_tick(directed[i]);
		drain();

		write_radio(1'b1);
		send_random(500, -1);
		drain();

		// radio off: ticks are taken and dropped, last command is kept
		write_radio(1'b0);
		send_random(100, -1);
		drain();

		write_radio(1'b1);
		send_random(650, 200);
		drain();

		if (sb.errors == 0)
			$display("rc_differential_drive_mixer_top_tb: done, clean");
		else
			$display("rc_differential_drive_mixer_top_tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
src/rcdm_pkg.sv
src/rcdm_dp.sv
src/rcdm_ctrl.sv
src/rc_differential_drive_mixer_top.sv
tb/rcdm_tb_pkg.sv
tb/rc_differential_drive_mixer_top_tb.sv
